// File: design/adex_pkg.sv
package adex_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 4;
	localparam int TICK_W = 16;
	localparam int GAIN_W = 24;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 36;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIGIT_W = 4;
	localparam int DIGIT_N = MUL_B_W / DIGIT_W;
	localparam int CNT_W = $clog2(DIGIT_N);

	localparam int X_W = 21;
	localparam int Y_W = 22;
	localparam int MANT_W = 18;
	localparam int EXP_W = 33;
	localparam int SUM_W = 38;

	localparam logic signed [31:0] SLOPE_FACTOR = 32'sd131072;
	localparam logic signed [31:0] ADAPT_COUPLING = 32'sd262144;
	localparam logic [23:0] ADAPT_GAIN = 24'd11651;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	localparam logic signed [49:0] SLOPE_DIV = 50'(SLOPE_FACTOR);
	localparam logic signed [49:0] X_MAX = 50'sd720896;
	localparam logic signed [49:0] X_MIN = -50'sd786432;
	localparam logic [53:0] TERM_MAX = 54'd2147483647;

	localparam logic signed [31:0] REST_RST = -32'sd4626842;
	localparam logic signed [31:0] THRESH_RST = -32'sd3303014;
	localparam logic signed [31:0] PEAK_RST = 32'sd1310720;
	localparam logic signed [31:0] VRESET_RST = -32'sd4626842;
	localparam logic signed [31:0] INC_RST = 32'sd5275648;
	localparam logic [15:0] TICKS_RST = 16'd20;
	localparam logic [23:0] GLEAK_RST = 24'd179178;
	localparam logic [23:0] GIN_RST = 24'd5971;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REST = 4'd0,
		REG_THRESH = 4'd1,
		REG_PEAK = 4'd2,
		REG_VRESET = 4'd3,
		REG_INC = 4'd4,
		REG_TICKS = 4'd5,
		REG_GAIN_LEAK = 4'd6,
		REG_GAIN_INPUT = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rest;
		logic signed [DATA_W-1:0] thresh;
		logic signed [DATA_W-1:0] peak;
		logic signed [DATA_W-1:0] vreset;
		logic signed [DATA_W-1:0] inc;
		logic [TICK_W-1:0] ticks;
		logic [GAIN_W-1:0] gain_leak;
		logic [GAIN_W-1:0] gain_input;
	} cfg_t;

	function automatic logic [MANT_W-1:0] pow2_frac(input logic [4:0] idx);
		logic [MANT_W-1:0] r;
		case (idx)
			5'd0: r = 18'd65536;
			5'd1: r = 18'd68438;
			5'd2: r = 18'd71468;
			5'd3: r = 18'd74632;
			5'd4: r = 18'd77936;
			5'd5: r = 18'd81386;
			5'd6: r = 18'd84990;
			5'd7: r = 18'd88752;
			5'd8: r = 18'd92682;
			5'd9: r = 18'd96785;
			5'd10: r = 18'd101070;
			5'd11: r = 18'd105545;
			5'd12: r = 18'd110218;
			5'd13: r = 18'd115098;
			5'd14: r = 18'd120194;
			5'd15: r = 18'd125515;
			default: r = 18'd131072;
		endcase
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [71:0] x);
		logic signed [DATA_W-1:0] r;
		if (x > 72'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -72'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: design/adex_mul.sv
// Radix-16 serial-parallel multiplier: one digit of b per cycle, top digit signed.
module adex_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [adex_pkg::MUL_A_W-1:0] a,
	input logic signed [adex_pkg::MUL_B_W-1:0] b,
	output logic done,
	output logic signed [adex_pkg::MUL_P_W-1:0] prod
);
	localparam int AW = adex_pkg::MUL_A_W;
	localparam int BW = adex_pkg::MUL_B_W;
	localparam int PW = adex_pkg::MUL_P_W;
	localparam int DW = adex_pkg::DIGIT_W;
	localparam int CW = adex_pkg::CNT_W;
	localparam int HW = AW + 6;
	localparam int ACW = HW + BW;

	logic signed [AW-1:0] a_q;
	logic [BW-1:0] b_q;
	logic signed [ACW-1:0] acc_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic last;
	logic signed [DW:0] digit;
	logic signed [HW-1:0] hi;
	logic signed [ACW-1:0] acc_next;

	assign last = (cnt_q == CW'(adex_pkg::DIGIT_N - 1));
	assign digit = last ? $signed({b_q[DW-1], b_q[DW-1:0]}) : $signed({1'b0, b_q[DW-1:0]});
	assign hi = $signed(acc_q[ACW-1:BW]) + HW'(a_q) * HW'(digit);
	assign acc_next = $signed({hi, acc_q[BW-1:0]}) >>> DW;
	assign done = done_q;
	assign prod = acc_q[PW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q <= b_q >> DW;
			acc_q <= acc_next;
		end
	end

endmodule

// File: design/adex_cfg.sv
module adex_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [adex_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [adex_pkg::DATA_W-1:0] cfg_data,
	output adex_pkg::cfg_t regs
);
	adex_pkg::cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.rest <= adex_pkg::REST_RST;
			regs_q.thresh <= adex_pkg::THRESH_RST;
			regs_q.peak <= adex_pkg::PEAK_RST;
			regs_q.vreset <= adex_pkg::VRESET_RST;
			regs_q.inc <= adex_pkg::INC_RST;
			regs_q.ticks <= adex_pkg::TICKS_RST;
			regs_q.gain_leak <= adex_pkg::GLEAK_RST;
			regs_q.gain_input <= adex_pkg::GIN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				adex_pkg::REG_REST: regs_q.rest <= cfg_data;
				adex_pkg::REG_THRESH: regs_q.thresh <= cfg_data;
				adex_pkg::REG_PEAK: regs_q.peak <= cfg_data;
				adex_pkg::REG_VRESET: regs_q.vreset <= cfg_data;
				adex_pkg::REG_INC: regs_q.inc <= cfg_data;
				adex_pkg::REG_TICKS: regs_q.ticks <= cfg_data[adex_pkg::TICK_W-1:0];
				adex_pkg::REG_GAIN_LEAK: regs_q.gain_leak <= cfg_data[adex_pkg::GAIN_W-1:0];
				adex_pkg::REG_GAIN_INPUT: regs_q.gain_input <= cfg_data[adex_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: design/adex_neuron_euler_step_top.sv
// One AdEx neuron advanced by one Euler step per input transaction. All products run
// through a single radix-16 serial multiplier, each product launched and then captured
// when it is done. A normal step takes seven products from acceptance to the result
// register; a refractory step takes two products. A new input is taken while the
// previous result waits at the output.
module adex_neuron_euler_step_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] input_current,
	output logic out_valid,
	input logic out_ready,
	output logic spiked,
	output logic signed [31:0] voltage_out,
	output logic signed [31:0] adaptation_out,
	output logic refractory,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [adex_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [adex_pkg::DATA_W-1:0] cfg_data
);
	localparam int AW = adex_pkg::MUL_A_W;
	localparam int BW = adex_pkg::MUL_B_W;
	localparam int PW = adex_pkg::MUL_P_W;
	localparam int XW = adex_pkg::X_W;
	localparam int YW = adex_pkg::Y_W;
	localparam int MW = adex_pkg::MANT_W;
	localparam int EW = adex_pkg::EXP_W;
	localparam int SW = adex_pkg::SUM_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LAUNCH = 4'b0010,
		S_WAIT = 4'b0100,
		S_FIN = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		OP_COUP = 3'd0,
		OP_DW = 3'd1,
		OP_X = 3'd2,
		OP_INT = 3'd3,
		OP_TERM = 3'd4,
		OP_LEAK = 3'd5,
		OP_IN = 3'd6
	} op_t;

	adex_pkg::cfg_t cfg;
	state_t state_q;
	op_t op_q;

	logic signed [31:0] v_q, w_q, cur_q, coup_q, wn_q, nv_q;
	logic [15:0] rc_q, nrc_q;
	logic signed [YW-1:0] y_q;
	logic [EW-1:0] e_q;
	logic [31:0] term_q;
	logic signed [35:0] t1_q;
	logic spk_q, refr_q;
	logic out_valid_q, spk_out_q, refr_out_q;
	logic signed [31:0] volt_out_q, adapt_out_q;

	logic mul_start, mul_done;
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;

	logic signed [32:0] vmel, vmth;
	logic signed [49:0] xnum, xdiv;
	logic signed [XW-1:0] x_cl;
	logic [3:0] idx;
	logic [MW-1:0] frac_base, frac_step, mant;
	logic signed [5:0] expo;
	logic [5:0] rsh;
	logic [EW-1:0] e_next;
	logic signed [PW-1:0] p16, p24, p30;
	logic signed [35:0] t2;
	logic signed [SW-1:0] vw;
	logic take_out;

	adex_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.regs(cfg)
	);

	adex_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.a(mul_a),
		.b(mul_b),
		.done(mul_done),
		.prod(mul_p)
	);

	assign in_ready = (state_q == S_IDLE);
	assign mul_start = (state_q == S_LAUNCH);
	assign take_out = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign spiked = spk_out_q;
	assign voltage_out = volt_out_q;
	assign adaptation_out = adapt_out_q;
	assign refractory = refr_out_q;

	assign vmel = 33'(v_q) - 33'(cfg.rest);
	assign vmth = 33'(v_q) - 33'(cfg.thresh);
	assign xnum = 50'($signed({vmth, 16'h0000}));
	assign xdiv = xnum / adex_pkg::SLOPE_DIV;

	always_comb begin
		if (xdiv > adex_pkg::X_MAX) begin
			x_cl = adex_pkg::X_MAX[XW-1:0];
		end else if (xdiv < adex_pkg::X_MIN) begin
			x_cl = adex_pkg::X_MIN[XW-1:0];
		end else begin
			x_cl = xdiv[XW-1:0];
		end
	end

	assign idx = y_q[15:12];
	assign frac_base = adex_pkg::pow2_frac({1'b0, idx});
	assign frac_step = adex_pkg::pow2_frac(5'({1'b0, idx}) + 5'd1) - frac_base;
	assign mant = frac_base + mul_p[29:12];
	assign expo = y_q[YW-1:16];
	assign rsh = 6'(-expo);
	assign e_next = expo[5] ? (EW'(mant) >> rsh) : (EW'(mant) << expo[4:0]);

	assign p16 = mul_p >>> 16;
	assign p24 = mul_p >>> 24;
	assign p30 = mul_p >>> 30;
	assign t2 = p24[35:0];
	assign vw = SW'(v_q) + SW'(t1_q) + SW'(t2);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_COUP: begin
				mul_a = AW'(adex_pkg::sat32(72'(vmel)));
				mul_b = BW'(adex_pkg::ADAPT_COUPLING);
			end
			OP_DW: begin
				mul_a = AW'(coup_q) - AW'(w_q);
				mul_b = BW'(adex_pkg::ADAPT_GAIN);
			end
			OP_X: begin
				mul_a = AW'(x_cl);
				mul_b = BW'(adex_pkg::LOG2E_Q30);
			end
			OP_INT: begin
				mul_a = AW'(frac_step);
				mul_b = BW'(y_q[11:0]);
			end
			OP_TERM: begin
				mul_a = AW'(e_q);
				mul_b = BW'(adex_pkg::SLOPE_FACTOR);
			end
			OP_LEAK: begin
				mul_a = AW'(term_q) - AW'(vmel);
				mul_b = BW'(cfg.gain_leak);
			end
			OP_IN: begin
				mul_a = AW'(cur_q) - AW'(w_q);
				mul_b = BW'(cfg.gain_input);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_COUP;
			out_valid_q <= 1'b0;
			v_q <= adex_pkg::REST_RST;
			w_q <= '0;
			rc_q <= '0;
		end else begin
			if (state_q == S_FIN && take_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q <= OP_COUP;
						state_q <= S_LAUNCH;
					end
				end
				S_LAUNCH: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mul_done) begin
						case (op_q)
							OP_COUP: begin
								op_q <= OP_DW;
								state_q <= S_LAUNCH;
							end
							OP_DW: begin
								if (rc_q != '0) begin
									state_q <= S_FIN;
								end else begin
									op_q <= OP_X;
									state_q <= S_LAUNCH;
								end
							end
							OP_X: begin
								op_q <= OP_INT;
								state_q <= S_LAUNCH;
							end
							OP_INT: begin
								op_q <= OP_TERM;
								state_q <= S_LAUNCH;
							end
							OP_TERM: begin
								op_q <= OP_LEAK;
								state_q <= S_LAUNCH;
							end
							OP_LEAK: begin
								op_q <= OP_IN;
								state_q <= S_LAUNCH;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_FIN: begin
					if (take_out) begin
						v_q <= nv_q;
						w_q <= wn_q;
						rc_q <= nrc_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_q <= input_current;
		end
		if (state_q == S_FIN && take_out) begin
			spk_out_q <= spk_q;
			refr_out_q <= refr_q;
			volt_out_q <= nv_q;
			adapt_out_q <= wn_q;
		end
		if (state_q == S_WAIT && mul_done) begin
			case (op_q)
				OP_COUP: coup_q <= adex_pkg::sat32(72'(p16));
				OP_DW: begin
					wn_q <= adex_pkg::sat32(72'(w_q) + 72'(p24));
					if (rc_q != '0) begin
						nv_q <= cfg.vreset;
						nrc_q <= rc_q - 1'b1;
						spk_q <= 1'b0;
						refr_q <= 1'b1;
					end
				end
				OP_X: y_q <= p30[YW-1:0];
				OP_INT: e_q <= e_next;
				OP_TERM: begin
					if (mul_p[PW-1:16] > adex_pkg::TERM_MAX) begin
						term_q <= 32'h7fffffff;
					end else begin
						term_q <= mul_p[47:16];
					end
				end
				OP_LEAK: t1_q <= p24[35:0];
				OP_IN: begin
					refr_q <= 1'b0;
					if (vw >= SW'(cfg.peak)) begin
						spk_q <= 1'b1;
						nv_q <= cfg.vreset;
						nrc_q <= cfg.ticks;
						wn_q <= adex_pkg::sat32(72'(wn_q) + 72'(cfg.inc));
					end else begin
						spk_q <= 1'b0;
						nv_q <= adex_pkg::sat32(72'(vw));
						nrc_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: design/adex_chk.sv
module adex_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic spiked,
	input logic signed [31:0] voltage_out,
	input logic signed [31:0] adaptation_out,
	input logic refractory,
	input logic cfg_valid,
	input logic cfg_ready
);

	// The block works on one step at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a step was in progress");

	a_spike_not_refractory: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(spiked && refractory))
		else $error("spike reported during a refractory step");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(voltage_out)
			&& $stable(adaptation_out) && $stable(spiked)))
		else $error("stalled output transaction changed");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind adex_neuron_euler_step_top adex_chk u_adex_chk (.*);
